// ===== rtl/i2c_master_bit_engine_assert.svh =====
// assertion macros for the i2c master bit engine checker
// no dependencies; included by the checker file only
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// shared types, constants and decode helpers for the i2c master bit engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int RECOVERY_CLOCKS = 9;
    localparam int MODE_W          = 3;

    // longest command sequence sets the phase counter width
    localparam int WRITE_LEN   = 2 * BYTE_BITS + 1;
    localparam int RECOVER_LEN = 2 * RECOVERY_CLOCKS;
    localparam int SEQ_MAX     = (WRITE_LEN > RECOVER_LEN) ? WRITE_LEN : RECOVER_LEN;
    localparam int PHASE_W     = $clog2(SEQ_MAX);

    localparam int QUEUE_DEPTH = 2;

    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [BYTE_BITS-1:0] byte_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 3'd0,
        MODE_STOP    = 3'd1,
        MODE_WRITE   = 3'd2,
        MODE_READ    = 3'd3,
        MODE_ACK     = 3'd4,
        MODE_NACK    = 3'd5,
        MODE_RDACK   = 3'd6,
        MODE_RECOVER = 3'd7
    } mode_e;

    // one classified bus slot as it travels from front to back
    typedef struct packed {
        logic   cmd_valid;
        mode_e  mode;
        byte_t  write_byte;
        logic   sda_in;
        phase_t last;
    } slot_t;

    // index of the final phase of each command sequence
    function automatic phase_t seq_last(input mode_e m);
        phase_t r;
        case (m)
            MODE_WRITE:   r = phase_t'(WRITE_LEN - 1);
            MODE_READ:    r = phase_t'(2 * BYTE_BITS - 1);
            MODE_RECOVER: r = phase_t'(RECOVER_LEN - 1);
            default:      r = phase_t'(2);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cm_ifs.sv =====
// valid/ready channel interfaces for bus slots in and results out
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd_valid;
    logic [i2cm_pkg::MODE_W-1:0]       mode;
    logic [i2cm_pkg::BYTE_BITS-1:0]    write_byte;
    logic                              sda_in;

    modport source (output valid, cmd_valid, mode, write_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, mode, write_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              scl_level;
    logic                              sda_level;
    logic                              busy_res;
    logic                              done_res;
    logic [i2cm_pkg::BYTE_BITS-1:0]    read_byte;
    logic                              ack_bit;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    ack_bit, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    ack_bit, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_front.sv =====
// front end: takes bus slots and classifies the command they carry
// depends on i2cm_pkg and i2cm_req_if
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
    i2cm_req_if.sink         req,
    output i2cm_pkg::slot_t  slot,
    output logic             slot_valid,
    input  logic             slot_ready
);

    i2cm_pkg::mode_e mode_dec;

    always_comb
    begin
        mode_dec        = i2cm_pkg::mode_e'(req.mode);
        slot.cmd_valid  = req.cmd_valid;
        slot.mode       = mode_dec;
        slot.write_byte = req.write_byte;
        slot.sda_in     = req.sda_in;
        slot.last       = i2cm_pkg::seq_last(mode_dec);
    end

    assign slot_valid = req.valid;
    assign req.ready  = slot_ready;

endmodule

`default_nettype wire

// ===== rtl/i2cm_queue.sv =====
// two-entry slot queue between front and back ends
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  i2cm_pkg::slot_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output i2cm_pkg::slot_t  pop_data
);

    localparam int PTR_W = (i2cm_pkg::QUEUE_DEPTH > 1) ? $clog2(i2cm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

    i2cm_pkg::slot_t     mem_reg [i2cm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2cm_back.sv =====
// back end: phase sequencer, shift registers, line drives and result register
// depends on i2cm_pkg and i2cm_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             slot_valid,
    output logic             slot_ready,
    input  i2cm_pkg::slot_t  slot,
    i2cm_rsp_if.source       rsp
);

    localparam int BB = i2cm_pkg::BYTE_BITS;

    i2cm_pkg::mode_e   mode_reg,  mode_next;
    i2cm_pkg::phase_t  phase_reg, phase_next;
    i2cm_pkg::phase_t  last_reg,  last_next;
    logic              busy_reg,  busy_next;
    i2cm_pkg::byte_t   tx_reg,    tx_next;
    i2cm_pkg::byte_t   rx_reg,    rx_next;
    logic              ack_reg,   ack_next;
    logic              scl_reg,   scl_next;
    logic              sda_reg,   sda_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_busy_reg,  out_busy_next;
    logic              out_done_reg,  out_done_next;

    logic              take;
    logic              start;
    logic              run;
    logic              done;
    i2cm_pkg::phase_t  ph;
    i2cm_pkg::byte_t   tx_cur;
    i2cm_pkg::byte_t   rx_cur;

    assign slot_ready = !out_valid_reg || rsp.ready;
    assign take       = slot_valid && slot_ready;

    always_comb
    begin
        start     = !busy_reg && slot.cmd_valid;
        run       = busy_reg || slot.cmd_valid;
        mode_next = start ? slot.mode : mode_reg;
        last_next = start ? slot.last : last_reg;
        ph        = start ? '0 : phase_reg;
        tx_cur    = (start && slot.mode == i2cm_pkg::MODE_WRITE) ? slot.write_byte : tx_reg;
        rx_cur    = (start && slot.mode == i2cm_pkg::MODE_READ) ? '0 : rx_reg;

        tx_next  = tx_cur;
        rx_next  = rx_cur;
        ack_next = ack_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        done     = 1'b0;

        if (run)
        begin
            done = (ph == last_next);
            case (mode_next)
                i2cm_pkg::MODE_START:
                begin
                    if (ph == i2cm_pkg::phase_t'(0))
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else if (ph == i2cm_pkg::phase_t'(1))
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::MODE_STOP:
                begin
                    if (ph == i2cm_pkg::phase_t'(0))
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    else if (ph == i2cm_pkg::phase_t'(1))
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                end
                i2cm_pkg::MODE_WRITE:
                begin
                    if (done)
                    begin
                        // release sda for the slave ack
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (!ph[0])
                    begin
                        scl_next = 1'b0;
                        sda_next = tx_cur[BB-1];
                        tx_next  = {tx_cur[BB-2:0], 1'b0};
                    end
                    else
                    begin
                        scl_next = 1'b1;
                    end
                end
                i2cm_pkg::MODE_READ:
                begin
                    if (!ph[0])
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        rx_next  = {rx_cur[BB-2:0], slot.sda_in};
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::MODE_ACK,
                i2cm_pkg::MODE_NACK:
                begin
                    if (ph == i2cm_pkg::phase_t'(0))
                    begin
                        scl_next = 1'b0;
                        sda_next = (mode_next == i2cm_pkg::MODE_NACK);
                    end
                    else if (ph == i2cm_pkg::phase_t'(1))
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::MODE_RDACK:
                begin
                    if (ph == i2cm_pkg::phase_t'(0))
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (ph == i2cm_pkg::phase_t'(1))
                    begin
                        scl_next = 1'b1;
                        ack_next = slot.sda_in;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                default:
                begin
                    // recovery clocks with sda released
                    sda_next = 1'b1;
                    scl_next = !ph[0];
                end
            endcase
        end

        busy_next     = run && !done;
        phase_next    = (run && !done) ? ph + i2cm_pkg::phase_t'(1) : '0;
        out_busy_next = run;
        out_done_next = done;

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= i2cm_pkg::MODE_START;
            phase_reg     <= '0;
            last_reg      <= '0;
            busy_reg      <= 1'b0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            ack_reg       <= 1'b1;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            out_busy_reg  <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                mode_reg     <= mode_next;
                phase_reg    <= phase_next;
                last_reg     <= last_next;
                busy_reg     <= busy_next;
                tx_reg       <= tx_next;
                rx_reg       <= rx_next;
                ack_reg      <= ack_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                out_busy_reg <= out_busy_next;
                out_done_reg <= out_done_next;
            end
        end
    end

    // state only moves when the result register is free, so it doubles as the payload
    assign rsp.valid     = out_valid_reg;
    assign rsp.scl_level = scl_reg;
    assign rsp.sda_level = sda_reg;
    assign rsp.busy_res  = out_busy_reg;
    assign rsp.done_res  = out_done_reg;
    assign rsp.read_byte = rx_reg;
    assign rsp.ack_bit   = ack_reg;

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// top level of the i2c master bit engine: front end, slot queue and back end
// depends on i2cm_pkg, i2cm_ifs, i2cm_front, i2cm_queue and i2cm_back
`timescale 1ns / 1ps
`default_nettype none

// usage
// - req channel: one transaction per bus time slot, carrying an optional command
//   (cmd_valid, mode, write_byte) and the sampled sda level of that slot
// - rsp channel: exactly one transaction per req transaction, in order, with
//   the scl/sda drives after the slot, busy/done flags, last read byte and ack bit
// - path: the edge that takes a slot writes it into the queue; the back end
//   then runs it through the sequencer into the result register, which drives
//   rsp.valid and the rsp payload
// - throughput: one slot per clock while rsp is not stalled; the sequencer
//   advances one phase per slot and its next-state logic is the only loop
// - a command offered while another runs is ignored; an idle engine runs the
//   first phase of a new command in the same slot
// - reset: asynchronous, active low; lines released, ack bit high, engine idle,
//   queue and result register empty
// - rsp stall: the result register holds, the two-entry queue keeps taking
//   slots until full, then req.ready drops

module i2c_master_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    i2cm_req_if.sink    req,
    i2cm_rsp_if.source  rsp
);

    // front end to queue
    i2cm_pkg::slot_t  fe_slot;
    logic             fe_valid;
    logic             fe_ready;

    // queue to back end
    i2cm_pkg::slot_t  be_slot;
    logic             be_valid;
    logic             be_ready;

    // decode of the incoming slot
    i2cm_front u_front (
        .req        (req),
        .slot       (fe_slot),
        .slot_valid (fe_valid),
        .slot_ready (fe_ready)
    );

    // lets the front keep taking slots while the result waits
    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_slot),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (be_slot)
    );

    // phase sequencer and result register
    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (be_valid),
        .slot_ready (be_ready),
        .slot       (be_slot),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
// port-level checks on the i2c master bit engine result channel, bound to the top
// depends on i2c_master_bit_engine_assert.svh and i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            scl_level,
    input wire logic                            sda_level,
    input wire logic                            busy_res,
    input wire logic                            done_res,
    input wire logic [i2cm_pkg::BYTE_BITS-1:0]  read_byte,
    input wire logic                            ack_bit
);

    // whole result payload, and the part an idle slot leaves alone
    logic [i2cm_pkg::BYTE_BITS+4:0] payload;
    logic [i2cm_pkg::BYTE_BITS+2:0] held;

    assign payload = {scl_level, sda_level, busy_res, done_res, read_byte, ack_bit};
    assign held    = {scl_level, sda_level, read_byte, ack_bit};

    `I2CM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(payload), "result changed while stalled")
    `I2CM_ASSERT_NOW(a_done_busy, rsp_valid && done_res, busy_res, "done without busy")
    `I2CM_ASSERT_NOW(a_idle_holds, (rsp_valid && rsp_ready) ##1 (rsp_valid && !busy_res),
                     $stable(held), "idle slot changed state")
    `I2CM_ASSERT_NOW(a_reset_empty, $rose(rst_n), !rsp_valid, "result present after reset")

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .scl_level (rsp.scl_level),
    .sda_level (rsp.sda_level),
    .busy_res  (rsp.busy_res),
    .done_res  (rsp.done_res),
    .read_byte (rsp.read_byte),
    .ack_bit   (rsp.ack_bit)
);

`default_nettype wire

// ===== dv/i2cm_slot_checker.sv =====
// checker for the i2c master bit engine: per-slot line predictor and result scoreboard
// depends on i2cm_pkg and the i2cm_req_if / i2cm_rsp_if interfaces
`timescale 1ns / 1ps

module i2cm_slot_checker (
    input  logic clk,
    input  logic rst_n,
    i2cm_req_if  req,
    i2cm_rsp_if  rsp,
    output int   failures,
    output int   waiting
);

    typedef struct packed {
        logic            scl;
        logic            sda;
        logic            busy;
        logic            done;
        i2cm_pkg::byte_t rd;
        logic            ack;
    } line_state_t;

    line_state_t expected_drives[$];

    // own copy of the engine state
    i2cm_pkg::mode_e run_mode;
    logic [4:0]      step_no;
    logic            engaged;
    i2cm_pkg::byte_t tx_bits;
    i2cm_pkg::byte_t rx_bits;
    logic            ack_seen;
    logic            scl_out;
    logic            sda_out;

    int fail_total;
    int result_no;

    function automatic int slots_of(input i2cm_pkg::mode_e m);
        case (m)
            i2cm_pkg::MODE_WRITE:   return 2 * i2cm_pkg::BYTE_BITS + 1;
            i2cm_pkg::MODE_READ:    return 2 * i2cm_pkg::BYTE_BITS;
            i2cm_pkg::MODE_RECOVER: return 2 * i2cm_pkg::RECOVERY_CLOCKS;
            default:                return 3;
        endcase
    endfunction

    task automatic predict_bus_slot(input logic cv, input i2cm_pkg::mode_e m,
                                    input i2cm_pkg::byte_t wb, input logic sda,
                                    output line_state_t r);
        int len;
        r = '0;
        if (!engaged && cv)
        begin
            engaged  = 1'b1;
            run_mode = m;
            step_no  = '0;
            if (m == i2cm_pkg::MODE_WRITE)
                tx_bits = wb;
            if (m == i2cm_pkg::MODE_READ)
                rx_bits = '0;
        end
        if (engaged)
        begin
            len    = slots_of(run_mode);
            r.busy = 1'b1;
            case (run_mode)
                i2cm_pkg::MODE_START:
                begin
                    if (step_no == 0)
                    begin
                        scl_out = 1'b1;
                        sda_out = 1'b1;
                    end
                    else if (step_no == 1)
                    begin
                        scl_out = 1'b1;
                        sda_out = 1'b0;
                    end
                    else
                        scl_out = 1'b0;
                end
                i2cm_pkg::MODE_STOP:
                begin
                    scl_out = (step_no != 0);
                    sda_out = (step_no == 2);
                end
                i2cm_pkg::MODE_WRITE:
                begin
                    if (int'(step_no) < 2 * i2cm_pkg::BYTE_BITS)
                    begin
                        if (!step_no[0])
                        begin
                            scl_out = 1'b0;
                            sda_out = tx_bits[i2cm_pkg::BYTE_BITS-1];
                            tx_bits = tx_bits << 1;
                        end
                        else
                            scl_out = 1'b1;
                    end
                    else
                    begin
                        scl_out = 1'b0;
                        sda_out = 1'b1;
                    end
                end
                i2cm_pkg::MODE_READ:
                begin
                    if (!step_no[0])
                    begin
                        scl_out = 1'b1;
                        sda_out = 1'b1;
                        rx_bits = {rx_bits[i2cm_pkg::BYTE_BITS-2:0], sda};
                    end
                    else
                        scl_out = 1'b0;
                end
                i2cm_pkg::MODE_ACK, i2cm_pkg::MODE_NACK:
                begin
                    if (step_no == 0)
                    begin
                        scl_out = 1'b0;
                        sda_out = (run_mode == i2cm_pkg::MODE_NACK);
                    end
                    else
                        scl_out = (step_no == 1);
                end
                i2cm_pkg::MODE_RDACK:
                begin
                    if (step_no == 0)
                    begin
                        scl_out = 1'b0;
                        sda_out = 1'b1;
                    end
                    else if (step_no == 1)
                    begin
                        scl_out  = 1'b1;
                        ack_seen = sda;
                    end
                    else
                        scl_out = 1'b0;
                end
                default:
                begin
                    sda_out = 1'b1;
                    scl_out = !step_no[0];
                end
            endcase
            if (int'(step_no) + 1 >= len)
            begin
                r.done  = 1'b1;
                engaged = 1'b0;
                step_no = '0;
            end
            else
                step_no = step_no + 1'b1;
        end
        r.scl = scl_out;
        r.sda = sda_out;
        r.rd  = rx_bits;
        r.ack = ack_seen;
    endtask

    task automatic note_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t result %0d: %s expected %0h got %0h",
                         $time, result_no, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_state_t want;
        line_state_t got;
        if (!rst_n)
        begin
            run_mode   = i2cm_pkg::MODE_START;
            step_no    = '0;
            engaged    = 1'b0;
            tx_bits    = '0;
            rx_bits    = '0;
            ack_seen   = 1'b1;
            scl_out    = 1'b1;
            sda_out    = 1'b1;
            fail_total = 0;
            result_no  = 0;
            expected_drives.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.scl  = rsp.scl_level;
                got.sda  = rsp.sda_level;
                got.busy = rsp.busy_res;
                got.done = rsp.done_res;
                got.rd   = rsp.read_byte;
                got.ack  = rsp.ack_bit;
                if (expected_drives.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t result %0d arrived with nothing expected",
                                 $time, result_no);
                end
                else
                begin
                    want = expected_drives.pop_front();
                    note_field("scl_level", 8'(want.scl), 8'(got.scl));
                    note_field("sda_level", 8'(want.sda), 8'(got.sda));
                    note_field("busy_res", 8'(want.busy), 8'(got.busy));
                    note_field("done_res", 8'(want.done), 8'(got.done));
                    note_field("read_byte", want.rd, got.rd);
                    note_field("ack_bit", 8'(want.ack), 8'(got.ack));
                end
                result_no++;
            end
            if (req.valid && req.ready)
            begin
                predict_bus_slot(req.cmd_valid, i2cm_pkg::mode_e'(req.mode), req.write_byte,
                                 req.sda_in, want);
                expected_drives.push_back(want);
            end
        end
        failures <= fail_total;
        waiting  <= expected_drives.size();
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the i2c master bit engine: clock, reset, slot stimulus and verdict
// depends on i2cm_pkg, i2cm_ifs, i2c_master_bit_engine and i2cm_slot_checker
`timescale 1ns / 1ps

module tb;

    // how the sampled sda level is filled in over a command
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    localparam int RANDOM_SLOTS = 500;

    logic clk;
    logic rst_n;
    bit   quiet;     // set for a stretch with no idling on either side
    int   sent;      // accepted slot transactions in the current part
    int   failures;
    int   waiting;

    i2cm_req_if req_ch();
    i2cm_rsp_if rsp_ch();

    i2c_master_bit_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // watches both channels, predicts every slot and scores the results
    i2cm_slot_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .waiting  (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: stalls in roughly one cycle of seven, never during the quiet stretch
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    // number of bus slots a command occupies once it is taken
    function automatic int cmd_slots(input i2cm_pkg::mode_e m);
        case (m)
            i2cm_pkg::MODE_WRITE:   return 2 * i2cm_pkg::BYTE_BITS + 1;
            i2cm_pkg::MODE_READ:    return 2 * i2cm_pkg::BYTE_BITS;
            i2cm_pkg::MODE_RECOVER: return 2 * i2cm_pkg::RECOVERY_CLOCKS;
            default:                return 3;
        endcase
    endfunction

    // offer one slot from a falling edge and hold it until the transaction completes;
    // valid is left high so a following slot can go out back to back
    task automatic send_slot(input logic cv, input i2cm_pkg::mode_e m,
                             input i2cm_pkg::byte_t wb, input logic s);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 14)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd_valid  <= cv;
        req_ch.mode       <= m;
        req_ch.write_byte <= wb;
        req_ch.sda_in     <= s;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
    endtask

    // one command and the filler slots that carry it to completion; with noise on,
    // some filler slots offer a command too, which a busy engine must ignore
    task automatic run_cmd(input i2cm_pkg::mode_e m, input i2cm_pkg::byte_t wb,
                           input int fill, input bit noisy);
        int   len;
        int   k;
        logic s;
        len = cmd_slots(m);
        for (k = 0; k < len; k++)
        begin
            case (fill)
                SDA_LOW:  s = 1'b0;
                SDA_HIGH: s = 1'b1;
                default:  s = 1'($urandom_range(1));
            endcase
            if (k == 0)
                send_slot(1'b1, m, wb, s);
            else
                send_slot(noisy && ($urandom_range(3) == 0),
                          i2cm_pkg::mode_e'($urandom_range(7)),
                          i2cm_pkg::byte_t'($urandom_range(255)), s);
        end
    endtask

    // drop valid and wait for every outstanding result
    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (waiting == 0);
    endtask

    initial
    begin
        int              pick;
        int              n;
        int              k;
        i2cm_pkg::byte_t b;

        rst_n             = 1'b0;
        quiet             = 1'b0;
        sent              = 0;
        req_ch.valid      = 1'b0;
        req_ch.cmd_valid  = 1'b0;
        req_ch.mode       = i2cm_pkg::MODE_START;
        req_ch.write_byte = '0;
        req_ch.sda_in     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        // idle slots straight after reset: lines released, ack bit high
        send_slot(1'b0, i2cm_pkg::MODE_WRITE, 8'hFF, 1'b1);
        send_slot(1'b0, i2cm_pkg::MODE_START, 8'h00, 1'b0);
        run_cmd(i2cm_pkg::MODE_START, 8'h00, SDA_HIGH, 1'b0);
        run_cmd(i2cm_pkg::MODE_WRITE, 8'hFF, SDA_RAND, 1'b0);
        run_cmd(i2cm_pkg::MODE_RDACK, 8'h00, SDA_LOW, 1'b0);
        run_cmd(i2cm_pkg::MODE_WRITE, 8'h00, SDA_RAND, 1'b1);
        run_cmd(i2cm_pkg::MODE_RDACK, 8'hFF, SDA_HIGH, 1'b1);
        run_cmd(i2cm_pkg::MODE_WRITE, 8'hA5, SDA_RAND, 1'b0);
        run_cmd(i2cm_pkg::MODE_WRITE, 8'h5A, SDA_RAND, 1'b1);
        // read of all ones then all zeros, the clear on read start shows in between
        run_cmd(i2cm_pkg::MODE_READ, 8'h00, SDA_HIGH, 1'b0);
        run_cmd(i2cm_pkg::MODE_ACK, 8'h00, SDA_RAND, 1'b0);
        // idle slot after ack: scl must stay low, sda still pulled low
        send_slot(1'b0, i2cm_pkg::MODE_STOP, 8'h00, 1'b1);
        run_cmd(i2cm_pkg::MODE_READ, 8'hFF, SDA_LOW, 1'b1);
        run_cmd(i2cm_pkg::MODE_NACK, 8'h00, SDA_RAND, 1'b1);
        run_cmd(i2cm_pkg::MODE_READ, 8'h3C, SDA_RAND, 1'b1);
        run_cmd(i2cm_pkg::MODE_STOP, 8'h00, SDA_RAND, 1'b0);
        run_cmd(i2cm_pkg::MODE_RECOVER, 8'h00, SDA_LOW, 1'b1);
        run_cmd(i2cm_pkg::MODE_STOP, 8'h00, SDA_RAND, 1'b1);

        // sender holds off until the engine has caught up
        hold_until_drained();

        // random part: mostly complete bus transfers with random content, the rest
        // lone commands, idle slots and bursts of stray commands
        sent = 0;
        while (sent < RANDOM_SLOTS)
        begin
            quiet = (sent >= 220 && sent < 380);
            pick  = $urandom_range(99);
            if (pick < 65)
            begin
                run_cmd(i2cm_pkg::MODE_START, i2cm_pkg::byte_t'($urandom_range(255)),
                        SDA_RAND, 1'($urandom_range(1)));
                run_cmd(i2cm_pkg::MODE_WRITE, i2cm_pkg::byte_t'($urandom_range(255)),
                        SDA_RAND, 1'($urandom_range(1)));
                run_cmd(i2cm_pkg::MODE_RDACK, 8'h00,
                        ($urandom_range(4) == 0) ? SDA_HIGH : SDA_LOW,
                        1'($urandom_range(1)));
                n = $urandom_range(3, 1);
                for (k = 0; k < n; k++)
                begin
                    b = i2cm_pkg::byte_t'($urandom_range(255));
                    if ($urandom_range(1))
                    begin
                        run_cmd(i2cm_pkg::MODE_WRITE, b, SDA_RAND, 1'($urandom_range(1)));
                        run_cmd(i2cm_pkg::MODE_RDACK, b, SDA_RAND, 1'($urandom_range(1)));
                    end
                    else
                    begin
                        run_cmd(i2cm_pkg::MODE_READ, b, SDA_RAND, 1'($urandom_range(1)));
                        run_cmd((k == n - 1 || $urandom_range(3) == 0) ?
                                i2cm_pkg::MODE_NACK : i2cm_pkg::MODE_ACK,
                                b, SDA_RAND, 1'($urandom_range(1)));
                    end
                end
                // occasional repeated start before the stop
                if ($urandom_range(9) == 0)
                    run_cmd(i2cm_pkg::MODE_START, 8'h00, SDA_RAND, 1'b1);
                run_cmd(i2cm_pkg::MODE_STOP, i2cm_pkg::byte_t'($urandom_range(255)),
                        SDA_RAND, 1'($urandom_range(1)));
            end
            else if (pick < 80)
                run_cmd(i2cm_pkg::mode_e'($urandom_range(7)),
                        i2cm_pkg::byte_t'($urandom_range(255)), SDA_RAND,
                        1'($urandom_range(1)));
            else if (pick < 90)
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    send_slot(1'b0, i2cm_pkg::mode_e'($urandom_range(7)),
                              i2cm_pkg::byte_t'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            else
            begin
                // stray commands; the first one with cmd_valid starts a sequence that runs
                // on through whatever slots follow, later ones are ignored while it is busy
                n = $urandom_range(6, 1);
                repeat (n)
                    send_slot(1'($urandom_range(1)), i2cm_pkg::mode_e'($urandom_range(7)),
                              i2cm_pkg::byte_t'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            if ($urandom_range(19) == 0)
                hold_until_drained();
        end
        quiet = 1'b0;

        hold_until_drained();
        // keep clocking in case anything unexpected is still on its way
        repeat (8) @(posedge clk);
        if (failures == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
